>>> rtl/kbb_pkg.sv
// ----------------------------------------------------------------------------
// kbb_pkg
// Shared field widths, codes and handshake structs for the keyed
// bounding box table.
// ----------------------------------------------------------------------------
package kbb_pkg;

	localparam int KEY_W    = 17;
	localparam int COUNTY_W = 17;
	localparam int LON_W    = 29;
	localparam int LAT_W    = 28;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	typedef logic [KEY_W-1:0]           key_t;
	typedef logic [COUNTY_W-1:0]        county_t;
	typedef logic signed [LON_W-1:0]    lon_t;
	typedef logic signed [LAT_W-1:0]    lat_t;

	// request opcodes
	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_LOCATE = 2'd1,
		OP_READ   = 2'd2
	} op_e;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_e;

	// commands to the box memory unit
	typedef enum logic [1:0] {
		BOX_READ   = 2'd0,
		BOX_WIDEN  = 2'd1,
		BOX_CREATE = 2'd2
	} box_cmd_e;

	// one row of the box memory
	typedef struct packed {
		county_t county;
		lon_t    east;
		lon_t    west;
		lat_t    north;
		lat_t    south;
	} box_t;

	typedef struct packed {
		logic     valid;
		box_cmd_e cmd;
	} box_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_rsp_t;

endpackage

>>> rtl/keyed_bounding_box_table_core.sv
// ----------------------------------------------------------------------------
// keyed_bounding_box_table_core
// Keyed table of bounding boxes: add points, locate keys, read entries.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and its result appears for exactly one cycle with done high; the
// receiver cannot stall it, so it must capture the result in that cycle.
// Add and locate walk the key memory one entry per cycle over indexes 1 to
// the current entry count, and a match ends the walk early; an add then
// widens the matching box or, if the table is not full, creates a new one;
// a read goes straight to the box memory. An invalid read or an unused
// opcode ends after decode. The entry count is cleared at reset, so the
// table is empty at once with no clearing pass; entries beyond the count
// are never read. The county register may be written at any time the block
// is idle and is always ready.
// ----------------------------------------------------------------------------
module keyed_bounding_box_table_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         start,
	output logic                         busy,
	input  logic [kbb_pkg::OP_W-1:0]     op,
	input  kbb_pkg::key_t                entry_key,
	input  kbb_pkg::lon_t                longitude,
	input  kbb_pkg::lat_t                latitude,
	input  logic [$clog2(TABLE_DEPTH)-1:0] entry_index,
	// result channel
	output logic                         done,
	output logic [$clog2(TABLE_DEPTH)-1:0] result_index,
	output kbb_pkg::key_t                key_out,
	output kbb_pkg::county_t             county_out,
	output kbb_pkg::lon_t                center_longitude,
	output kbb_pkg::lat_t                center_latitude,
	output logic [kbb_pkg::STATUS_W-1:0] status,
	// county register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  kbb_pkg::county_t             cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_BOX
	} state_t;

	state_t              state_q;
	kbb_pkg::op_e        op_q;
	kbb_pkg::key_t       key_q;
	kbb_pkg::lon_t       lon_q;
	kbb_pkg::lat_t       lat_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    count_q;
	kbb_pkg::county_t    county_code_q;

	logic                scan_go_q;
	logic                key_we_q;
	kbb_pkg::box_req_t   box_req_q;
	logic [IDX_W-1:0]    box_idx_q;

	logic                done_q;
	logic [IDX_W-1:0]    res_idx_q;
	kbb_pkg::key_t       res_key_q;
	kbb_pkg::county_t    res_county_q;
	kbb_pkg::lon_t       res_lon_q;
	kbb_pkg::lat_t       res_lat_q;
	kbb_pkg::status_e    res_status_q;

	kbb_pkg::scan_rsp_t  scan_rsp;
	logic [IDX_W-1:0]    scan_idx;
	kbb_pkg::key_t       key_rdata;
	logic                box_done;
	kbb_pkg::county_t    box_county;
	kbb_pkg::lon_t       box_lon;
	kbb_pkg::lat_t       box_lat;
	logic [IDX_W-1:0]    new_idx;
	logic                table_full;

	assign new_idx    = count_q + IDX_W'(1);
	assign table_full = (count_q == IDX_W'(TABLE_DEPTH - 1));

	// county register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			county_code_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			county_code_q <= cfg_data;
		end
	end

	kbb_key_scan #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W)
	) u_key_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_go    (scan_go_q),
		.scan_key   (key_q),
		.count      (count_q),
		.fetch_addr (idx_q),
		.we         (key_we_q),
		.waddr      (box_idx_q),
		.wdata      (key_q),
		.rsp        (scan_rsp),
		.hit_idx    (scan_idx),
		.rdata      (key_rdata)
	);

	kbb_box_unit #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W)
	) u_box_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (box_req_q),
		.idx        (box_idx_q),
		.county_in  (county_code_q),
		.lon        (lon_q),
		.lat        (lat_q),
		.done       (box_done),
		.county_out (box_county),
		.center_lon (box_lon),
		.center_lat (box_lat)
	);

	// request sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= kbb_pkg::OP_ADD;
			key_q        <= '0;
			lon_q        <= '0;
			lat_q        <= '0;
			idx_q        <= '0;
			count_q      <= '0;
			scan_go_q    <= 1'b0;
			key_we_q     <= 1'b0;
			box_req_q    <= '0;
			box_idx_q    <= '0;
			done_q       <= 1'b0;
			res_idx_q    <= '0;
			res_key_q    <= '0;
			res_county_q <= '0;
			res_lon_q    <= '0;
			res_lat_q    <= '0;
			res_status_q <= kbb_pkg::ST_OK;
		end else begin
			done_q          <= 1'b0;
			scan_go_q       <= 1'b0;
			key_we_q        <= 1'b0;
			box_req_q.valid <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= kbb_pkg::op_e'(op);
						key_q   <= entry_key;
						lon_q   <= longitude;
						lat_q   <= latitude;
						idx_q   <= entry_index;
						state_q <= S_DECODE;
					end
				end

				S_DECODE: begin
					// unused fields of every result are zero
					res_idx_q    <= '0;
					res_key_q    <= '0;
					res_county_q <= '0;
					res_lon_q    <= '0;
					res_lat_q    <= '0;
					res_status_q <= kbb_pkg::ST_OK;
					case (op_q)
						kbb_pkg::OP_ADD, kbb_pkg::OP_LOCATE: begin
							scan_go_q <= 1'b1;
							state_q   <= S_SCAN;
						end
						kbb_pkg::OP_READ: begin
							if (idx_q == '0 || idx_q > count_q) begin
								res_status_q <= kbb_pkg::ST_BAD_INDEX;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end else begin
								box_req_q.valid <= 1'b1;
								box_req_q.cmd   <= kbb_pkg::BOX_READ;
								box_idx_q       <= idx_q;
								state_q         <= S_BOX;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end

				S_SCAN: begin
					if (scan_rsp.done) begin
						if (op_q == kbb_pkg::OP_LOCATE) begin
							res_idx_q <= scan_idx;
							done_q    <= 1'b1;
							state_q   <= S_IDLE;
						end else if (scan_rsp.hit) begin
							// grow the box of the matching entry
							box_req_q.valid <= 1'b1;
							box_req_q.cmd   <= kbb_pkg::BOX_WIDEN;
							box_idx_q       <= scan_idx;
							state_q         <= S_BOX;
						end else if (table_full) begin
							res_status_q <= kbb_pkg::ST_FULL;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							// append a new entry after the last one
							count_q         <= new_idx;
							key_we_q        <= 1'b1;
							box_req_q.valid <= 1'b1;
							box_req_q.cmd   <= kbb_pkg::BOX_CREATE;
							box_idx_q       <= new_idx;
							state_q         <= S_BOX;
						end
					end
				end

				S_BOX: begin
					if (box_done) begin
						res_idx_q <= box_idx_q;
						if (op_q == kbb_pkg::OP_READ) begin
							res_key_q    <= key_rdata;
							res_county_q <= box_county;
							res_lon_q    <= box_lon;
							res_lat_q    <= box_lat;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign result_index     = res_idx_q;
	assign key_out          = res_key_q;
	assign county_out       = res_county_q;
	assign center_longitude = res_lon_q;
	assign center_latitude  = res_lat_q;
	assign status           = res_status_q;

endmodule

>>> rtl/kbb_key_scan.sv
// ----------------------------------------------------------------------------
// kbb_key_scan
// Key memory with a linear search engine: one stored key is fetched and
// compared per cycle over indexes 1 to count; also serves key reads.
// ----------------------------------------------------------------------------
module kbb_key_scan #(
	parameter int TABLE_DEPTH = 1024,
	parameter int IDX_W       = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                scan_go,
	input  kbb_pkg::key_t       scan_key,
	input  logic [IDX_W-1:0]    count,
	input  logic [IDX_W-1:0]    fetch_addr,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  kbb_pkg::key_t       wdata,
	output kbb_pkg::scan_rsp_t  rsp,
	output logic [IDX_W-1:0]    hit_idx,
	output kbb_pkg::key_t       rdata
);

	kbb_pkg::key_t      mem [TABLE_DEPTH];
	kbb_pkg::key_t      rdata_s1;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               issuing_q;
	logic [IDX_W-1:0]   issue_idx_q;
	logic [IDX_W-1:0]   last_q;
	kbb_pkg::key_t      key_q;
	kbb_pkg::scan_rsp_t rsp_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   raddr;

	// scan owns the read port while it issues, otherwise it serves fetches
	assign raddr = issuing_q ? issue_idx_q : fetch_addr;

	// key memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// issue and compare pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q   <= 1'b0;
			issue_idx_q <= '0;
			last_q      <= '0;
			key_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			rsp_q       <= '0;
			hit_idx_q   <= '0;
		end else begin
			rsp_q      <= '0;
			cmp_vld_s1 <= issuing_q;
			cmp_idx_s1 <= issue_idx_q;

			if (scan_go) begin
				key_q  <= scan_key;
				last_q <= count;
				if (count == '0) begin
					rsp_q.done <= 1'b1;
					hit_idx_q  <= '0;
				end else begin
					issuing_q   <= 1'b1;
					issue_idx_q <= IDX_W'(1);
				end
			end else if (issuing_q) begin
				if (issue_idx_q == last_q) begin
					issuing_q <= 1'b0;
				end else begin
					issue_idx_q <= issue_idx_q + IDX_W'(1);
				end
			end

			// first match ends the search
			if (cmp_vld_s1) begin
				if (rdata_s1 == key_q) begin
					rsp_q.done <= 1'b1;
					rsp_q.hit  <= 1'b1;
					hit_idx_q  <= cmp_idx_s1;
					issuing_q  <= 1'b0;
					cmp_vld_s1 <= 1'b0;
				end else if (cmp_idx_s1 == last_q) begin
					rsp_q.done <= 1'b1;
					hit_idx_q  <= '0;
				end
			end
		end
	end

	assign rsp     = rsp_q;
	assign hit_idx = hit_idx_q;
	assign rdata   = rdata_s1;

endmodule

>>> rtl/kbb_box_unit.sv
// ----------------------------------------------------------------------------
// kbb_box_unit
// Box memory holding county and bounds per entry: creates rows, widens a
// row by read-modify-write and reads back the box midpoints.
// ----------------------------------------------------------------------------
module kbb_box_unit #(
	parameter int TABLE_DEPTH = 1024,
	parameter int IDX_W       = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kbb_pkg::box_req_t  req,
	input  logic [IDX_W-1:0]   idx,
	input  kbb_pkg::county_t   county_in,
	input  kbb_pkg::lon_t      lon,
	input  kbb_pkg::lat_t      lat,
	output logic               done,
	output kbb_pkg::county_t   county_out,
	output kbb_pkg::lon_t      center_lon,
	output kbb_pkg::lat_t      center_lat
);

	kbb_pkg::box_t             mem [TABLE_DEPTH];
	kbb_pkg::box_t             rdata_s1;
	logic                      vld_s1;
	kbb_pkg::box_cmd_e         cmd_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      done_q;
	kbb_pkg::county_t          county_q;
	kbb_pkg::lon_t             center_lon_q;
	kbb_pkg::lat_t             center_lat_q;

	logic                      wr_en;
	logic [IDX_W-1:0]          wr_addr;
	kbb_pkg::box_t             wr_data;
	kbb_pkg::box_t             widened;
	kbb_pkg::box_t             fresh;
	logic signed [kbb_pkg::LON_W:0] lon_sum;
	logic signed [kbb_pkg::LON_W:0] lon_adj;
	logic signed [kbb_pkg::LAT_W:0] lat_sum;
	logic signed [kbb_pkg::LAT_W:0] lat_adj;

	// new row: box is the single point
	always_comb begin
		fresh.county = county_in;
		fresh.east   = lon;
		fresh.west   = lon;
		fresh.north  = lat;
		fresh.south  = lat;
	end

	// widen the fetched row to take in the point
	always_comb begin
		widened        = rdata_s1;
		widened.east   = (rdata_s1.east  < lon) ? lon : rdata_s1.east;
		widened.west   = (rdata_s1.west  > lon) ? lon : rdata_s1.west;
		widened.north  = (rdata_s1.north < lat) ? lat : rdata_s1.north;
		widened.south  = (rdata_s1.south > lat) ? lat : rdata_s1.south;
	end

	// create writes at request time, widen writes back in the cycle after the request
	always_comb begin
		if (vld_s1 && cmd_s1 == kbb_pkg::BOX_WIDEN) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
			wr_data = widened;
		end else begin
			wr_en   = req.valid && req.cmd == kbb_pkg::BOX_CREATE;
			wr_addr = idx;
			wr_data = fresh;
		end
	end

	// midpoints, halved with truncation toward zero
	always_comb begin
		lon_sum = {rdata_s1.east[kbb_pkg::LON_W-1], rdata_s1.east}
			+ {rdata_s1.west[kbb_pkg::LON_W-1], rdata_s1.west};
		lon_adj = lon_sum + $signed({{kbb_pkg::LON_W{1'b0}}, lon_sum[kbb_pkg::LON_W]});
		lat_sum = {rdata_s1.north[kbb_pkg::LAT_W-1], rdata_s1.north}
			+ {rdata_s1.south[kbb_pkg::LAT_W-1], rdata_s1.south};
		lat_adj = lat_sum + $signed({{kbb_pkg::LAT_W{1'b0}}, lat_sum[kbb_pkg::LAT_W]});
	end

	// box memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[idx];
	end

	// command pipeline and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			cmd_s1       <= kbb_pkg::BOX_READ;
			idx_s1       <= '0;
			done_q       <= 1'b0;
			county_q     <= '0;
			center_lon_q <= '0;
			center_lat_q <= '0;
		end else begin
			vld_s1 <= req.valid;
			cmd_s1 <= req.cmd;
			idx_s1 <= idx;
			done_q <= vld_s1;
			if (vld_s1) begin
				county_q     <= rdata_s1.county;
				center_lon_q <= lon_adj[kbb_pkg::LON_W:1];
				center_lat_q <= lat_adj[kbb_pkg::LAT_W:1];
			end
		end
	end

	assign done       = done_q;
	assign county_out = county_q;
	assign center_lon = center_lon_q;
	assign center_lat = center_lat_q;

endmodule

>>> rtl/kbb_checker.sv
// ----------------------------------------------------------------------------
// kbb_checker
// Port-level checks of the request and result sequencing of the table.
// ----------------------------------------------------------------------------
module kbb_checker #(
	parameter int IDX_W = 10
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [IDX_W-1:0]             result_index,
	input logic [kbb_pkg::STATUS_W-1:0] status
);

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a request");

	// a result only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result without a request in flight");

	// never two results in a row
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// failures report no index and no unknown status code
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != kbb_pkg::ST_OK) |->
			(result_index == '0 &&
			 (status == kbb_pkg::ST_FULL || status == kbb_pkg::ST_BAD_INDEX)))
		else $error("failing result with an index or bad status");

endmodule

bind keyed_bounding_box_table_core kbb_checker #(
	.IDX_W ($clog2(TABLE_DEPTH))
) u_kbb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_index (result_index),
	.status       (status)
);

>>> bench/kbb_table_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbb_table_sb_pkg
// Scoreboard for the keyed bounding box table. It keeps its own copy of the
// table and of the county register, works out the response to every accepted
// request and checks the responses of the block in order, field by field.
// ----------------------------------------------------------------------------
package kbb_table_sb_pkg;
	import kbb_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int NO_ENTRY    = 0;

	// opcode the block does not define; must leave the table alone
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef logic [IDX_W-1:0] index_t;

	typedef struct {
		index_t              index;
		key_t                key;
		county_t             county;
		lon_t                center_lon;
		lat_t                center_lat;
		logic [STATUS_W-1:0] status;
	} table_response_t;

	class kbb_table_scoreboard;
		county_t         county_reg;
		key_t            key_mem[TABLE_DEPTH];
		county_t         county_mem[TABLE_DEPTH];
		lon_t            east_mem[TABLE_DEPTH];
		lon_t            west_mem[TABLE_DEPTH];
		lat_t            north_mem[TABLE_DEPTH];
		lat_t            south_mem[TABLE_DEPTH];
		int              entry_count;
		int              mismatch_count;
		table_response_t awaited_responses[$];

		function new();
			county_reg     = '0;
			entry_count    = 0;
			mismatch_count = 0;
			foreach (key_mem[i]) begin
				key_mem[i]    = '0;
				county_mem[i] = '0;
				east_mem[i]   = '0;
				west_mem[i]   = '0;
				north_mem[i]  = '0;
				south_mem[i]  = '0;
			end
		endfunction

		// linear search over the live entries 1 to entry_count
		function int lookup_key(key_t k);
			for (int i = 1; i <= entry_count; i++) begin
				if (key_mem[i] == k)
					return i;
			end
			return NO_ENTRY;
		endfunction

		// update the table copy for one accepted request and queue its response
		function void apply_request(logic [OP_W-1:0] req_op, key_t k, lon_t lon, lat_t lat,
			index_t idx);
			table_response_t r;
			int              hit;
			longint          lon_sum;
			longint          lat_sum;
			r.index      = '0;
			r.key        = '0;
			r.county     = '0;
			r.center_lon = '0;
			r.center_lat = '0;
			r.status     = ST_OK;
			case (req_op)
			OP_ADD: begin
				hit = lookup_key(k);
				if (hit != NO_ENTRY) begin
					// grow the box just enough to take in the point
					if (east_mem[hit] < lon)
						east_mem[hit] = lon;
					if (west_mem[hit] > lon)
						west_mem[hit] = lon;
					if (north_mem[hit] < lat)
						north_mem[hit] = lat;
					if (south_mem[hit] > lat)
						south_mem[hit] = lat;
					r.index = index_t'(hit);
				end else if (entry_count >= TABLE_DEPTH - 1) begin
					r.status = ST_FULL;
				end else begin
					// new entry: box collapses to the single point
					entry_count++;
					key_mem[entry_count]    = k;
					county_mem[entry_count] = county_reg;
					east_mem[entry_count]   = lon;
					west_mem[entry_count]   = lon;
					north_mem[entry_count]  = lat;
					south_mem[entry_count]  = lat;
					r.index = index_t'(entry_count);
				end
			end
			OP_LOCATE: begin
				r.index = index_t'(lookup_key(k));
			end
			OP_READ: begin
				if (idx == 0 || idx > entry_count) begin
					r.status = ST_BAD_INDEX;
				end else begin
					// midpoints, division truncates toward zero
					lon_sum      = longint'(east_mem[idx]) + longint'(west_mem[idx]);
					lat_sum      = longint'(north_mem[idx]) + longint'(south_mem[idx]);
					r.index      = idx;
					r.key        = key_mem[idx];
					r.county     = county_mem[idx];
					r.center_lon = lon_t'(lon_sum / 2);
					r.center_lat = lat_t'(lat_sum / 2);
				end
			end
			default: begin
			end
			endcase
			awaited_responses.push_back(r);
		endfunction

		function string diff_text(string field, longint want, longint got);
			return $sformatf("%s expected %0d got %0d", field, want, got);
		endfunction

		task report(string what);
			mismatch_count++;
			$display("mismatch at %0t ns: %s", $time, what);
		endtask

		// compare one response from the block with the oldest awaited one
		task check_response(index_t idx, key_t k, county_t c, lon_t clon, lat_t clat,
			logic [STATUS_W-1:0] st);
			table_response_t e;
			if (awaited_responses.size() == 0) begin
				report($sformatf("response with index %0d and no request outstanding", idx));
				return;
			end
			e = awaited_responses.pop_front();
			if (idx !== e.index)
				report(diff_text("result_index", e.index, idx));
			if (k !== e.key)
				report(diff_text("key_out", e.key, k));
			if (c !== e.county)
				report(diff_text("county_out", e.county, c));
			if (clon !== e.center_lon)
				report(diff_text("center_longitude", e.center_lon, clon));
			if (clat !== e.center_lat)
				report(diff_text("center_latitude", e.center_lat, clat));
			if (st !== e.status)
				report(diff_text("status", e.status, st));
		endtask
	endclass

endpackage

>>> bench/tb_keyed_bounding_box_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_bounding_box_table_core
// Drives add, locate and read requests into the keyed bounding box table,
// with county register writes between phases, and checks every response
// against the scoreboard. Directed corner cases come first, then mixed
// random traffic over several county settings.
// ----------------------------------------------------------------------------
module tb_keyed_bounding_box_table_core;
	import kbb_pkg::*;
	import kbb_table_sb_pkg::*;

	localparam int LON_LIMIT    = 180000000;
	localparam int LAT_LIMIT    = 90000000;
	localparam int KEY_MAX      = 99999;
	localparam int COUNTY_MAX   = 99999;
	localparam int PHASE_ITEMS  = 145;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [OP_W-1:0]     op;
	key_t                entry_key;
	lon_t                longitude;
	lat_t                latitude;
	index_t              entry_index;
	logic                done;
	index_t              result_index;
	key_t                key_out;
	county_t             county_out;
	lon_t                center_longitude;
	lat_t                center_latitude;
	logic [STATUS_W-1:0] status;
	logic                cfg_valid;
	logic                cfg_ready;
	county_t             cfg_data;

	kbb_table_scoreboard table_sb;
	key_t                hot_keys[64];
	bit                  no_gaps;

	keyed_bounding_box_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.entry_key(entry_key),
		.longitude(longitude),
		.latitude(latitude),
		.entry_index(entry_index),
		.done(done),
		.result_index(result_index),
		.key_out(key_out),
		.county_out(county_out),
		.center_longitude(center_longitude),
		.center_latitude(center_latitude),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// each response is only there for one cycle, take it at the closing edge
	always @(posedge clk) begin
		if (arst_n && done)
			table_sb.check_response(result_index, key_out, county_out, center_longitude,
				center_latitude, status);
	end

	// idle cycles before a request: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic key_t rand_key();
		return key_t'($urandom_range(0, KEY_MAX));
	endfunction

	function automatic index_t rand_index();
		return index_t'($urandom_range(0, TABLE_DEPTH - 1));
	endfunction

	function automatic lon_t rand_lon();
		case ($urandom_range(0, 9))
		0: return lon_t'(-LON_LIMIT);
		1: return lon_t'(LON_LIMIT);
		default: return lon_t'(int'($urandom_range(0, 2 * LON_LIMIT)) - LON_LIMIT);
		endcase
	endfunction

	function automatic lat_t rand_lat();
		case ($urandom_range(0, 9))
		0: return lat_t'(-LAT_LIMIT);
		1: return lat_t'(LAT_LIMIT);
		default: return lat_t'(int'($urandom_range(0, 2 * LAT_LIMIT)) - LAT_LIMIT);
		endcase
	endfunction

	// mostly keys already in the table, then the hot set, then anything
	function automatic key_t pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55 && table_sb.entry_count > 0)
			return table_sb.key_mem[$urandom_range(1, table_sb.entry_count)];
		if (r < 85)
			return hot_keys[$urandom_range(0, 63)];
		return rand_key();
	endfunction

	// mostly live entries, with zero, one past the end and random indexes
	function automatic index_t pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75 && table_sb.entry_count > 0)
			return index_t'($urandom_range(1, table_sb.entry_count));
		if (r < 82)
			return '0;
		if (r < 90)
			return index_t'(table_sb.entry_count + 1);
		return rand_index();
	endfunction

	// present one request and hold it until the block takes it
	task automatic send_request(input logic [OP_W-1:0] req_op, input key_t k, input lon_t lon,
		input lat_t lat, input index_t idx);
		int gap;
		gap = pick_gap();
		if ($urandom_range(0, 63) == 0)
			no_gaps = !no_gaps;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		op          <= req_op;
		entry_key   <= k;
		longitude   <= lon;
		latitude    <= lat;
		entry_index <= idx;
		do @(posedge clk); while (busy);
		table_sb.apply_request(req_op, k, lon, lat, idx);
	endtask

	// wait until every response is in and the block is idle
	task automatic wait_idle();
		start <= 1'b0;
		while (table_sb.awaited_responses.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_county(input county_t value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		table_sb.county_reg = value;
	endtask

	// random mix of all opcodes; unused fields carry random noise
	task automatic run_mixed_traffic(input int n);
		logic [OP_W-1:0] req_op;
		key_t            k;
		index_t          idx;
		int              r;
		for (int i = 0; i < n; i++) begin
			r   = $urandom_range(0, 99);
			k   = rand_key();
			idx = rand_index();
			if (r < 45) begin
				req_op = OP_ADD;
				k      = pick_key();
			end else if (r < 65) begin
				req_op = OP_LOCATE;
				k      = pick_key();
			end else if (r < 93) begin
				req_op = OP_READ;
				idx    = pick_index();
			end else begin
				req_op = OP_UNUSED;
			end
			send_request(req_op, k, rand_lon(), rand_lat(), idx);
		end
	endtask

	initial begin
		table_sb = new();
		foreach (hot_keys[i])
			hot_keys[i] = rand_key();
		hot_keys[0] = '0;
		hot_keys[1] = key_t'(KEY_MAX);
		no_gaps     = 1'b0;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		op          <= OP_ADD;
		entry_key   <= '0;
		longitude   <= '0;
		latitude    <= '0;
		entry_index <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		write_county(county_t'(COUNTY_MAX));

		// empty table: reads are invalid, locates miss, unused opcode is inert
		send_request(OP_READ, '0, '0, '0, '0);
		send_request(OP_READ, '0, '0, '0, index_t'(1));
		send_request(OP_LOCATE, '0, '0, '0, '0);
		send_request(OP_UNUSED, key_t'(KEY_MAX), lon_t'(LON_LIMIT), lat_t'(LAT_LIMIT),
			index_t'(TABLE_DEPTH - 1));

		// new entry at one corner, widened to the opposite corner
		send_request(OP_ADD, '0, lon_t'(-LON_LIMIT), lat_t'(-LAT_LIMIT), '0);
		send_request(OP_ADD, '0, lon_t'(LON_LIMIT), lat_t'(LAT_LIMIT), '0);
		send_request(OP_READ, '0, '0, '0, index_t'(1));

		// point already inside the box leaves it unchanged
		send_request(OP_ADD, '0, '0, '0, '0);
		send_request(OP_READ, '0, '0, '0, index_t'(1));

		// odd sums truncate toward zero, positive and negative
		send_request(OP_ADD, key_t'(KEY_MAX), lon_t'(LON_LIMIT), lat_t'(LAT_LIMIT), '0);
		send_request(OP_ADD, key_t'(KEY_MAX), lon_t'(-1), lat_t'(-1), '0);
		send_request(OP_READ, '0, '0, '0, index_t'(2));
		send_request(OP_ADD, key_t'(12345), lon_t'(-3), lat_t'(-5), '0);
		send_request(OP_ADD, key_t'(12345), lon_t'(-4), lat_t'(-6), '0);

		// last entry readable, one past it and far beyond are not
		send_request(OP_READ, '0, '0, '0, index_t'(3));
		send_request(OP_READ, '0, '0, '0, index_t'(4));
		send_request(OP_READ, '0, '0, '0, index_t'(TABLE_DEPTH - 1));

		// locate hits including the last entry, and a miss
		send_request(OP_LOCATE, key_t'(KEY_MAX), '0, '0, '0);
		send_request(OP_LOCATE, key_t'(12345), '0, '0, '0);
		send_request(OP_LOCATE, key_t'(54321), '0, '0, '0);

		// unused opcode with live fields must not touch the entry
		send_request(OP_UNUSED, key_t'(12345), lon_t'(-LON_LIMIT), lat_t'(-LAT_LIMIT),
			index_t'(3));
		send_request(OP_READ, '0, '0, '0, index_t'(3));

		// random traffic over several county settings
		write_county(county_t'($urandom_range(1, COUNTY_MAX - 1)));
		run_mixed_traffic(PHASE_ITEMS);
		write_county('0);
		run_mixed_traffic(PHASE_ITEMS);
		write_county(county_t'($urandom_range(0, COUNTY_MAX)));
		run_mixed_traffic(PHASE_ITEMS);
		write_county(county_t'(COUNTY_MAX));
		run_mixed_traffic(PHASE_ITEMS);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (table_sb.mismatch_count == 0 && table_sb.awaited_responses.size() == 0)
			$display("tb_keyed_bounding_box_table_core passed");
		else
			$display("tb_keyed_bounding_box_table_core failed");
		$finish;
	end

	// watchdog, well above the slowest legal run
	initial begin
		#40_000_000;
		$display("tb_keyed_bounding_box_table_core failed");
		$finish;
	end

endmodule
